>>> hw/rtl/stack_with_reverse_defines.svh
// ----------------------------------------------------------------------------
// stack_with_reverse_defines
// assertion macros shared by the stack checker
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_REVERSE_DEFINES_SVH
`define STACK_WITH_REVERSE_DEFINES_SVH

// concurrent assertion, masked while reset is high
`define SWR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion, checked at every rising clock edge
`define SWR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// types and codes of the reversible lifo stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swr_pkg;

   localparam int WordW  = 32;
   localparam int DepthW = 7;

   localparam logic [1:0] MODE_PUSH    = 2'd0;
   localparam logic [1:0] MODE_POP     = 2'd1;
   localparam logic [1:0] MODE_REVERSE = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SWAP_LO,
      ST_SWAP_HI,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              load;
      logic [WordW-1:0]  data;
      logic [1:0]        status;
      logic [DepthW-1:0] depth_now;
   } result_type;

endpackage

>>> hw/rtl/swr_if.sv
// ----------------------------------------------------------------------------
// swr_if
// valid/ready channels for stack requests and responses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swr_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [swr_pkg::WordW-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface swr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [swr_pkg::WordW-1:0]  data;
   logic [1:0]                status;
   logic [swr_pkg::DepthW-1:0] depth_now;

   modport source (output valid, output data, output status, output depth_now, input ready);
   modport sink (input valid, input data, input status, input depth_now, output ready);
endinterface

>>> hw/rtl/swr_mem.sv
// ----------------------------------------------------------------------------
// swr_mem
// element store, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_mem #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr0,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr1,
   output logic [swr_pkg::WordW-1:0]    rd_data0,
   output logic [swr_pkg::WordW-1:0]    rd_data1,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [swr_pkg::WordW-1:0]    wr_data
);

   logic [swr_pkg::WordW-1:0] mem [DEPTH];
   logic [swr_pkg::WordW-1:0] rd_data0_ff;
   logic [swr_pkg::WordW-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data0_ff <= mem[rd_addr0];
      rd_data1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> hw/rtl/swr_ctrl.sv
// ----------------------------------------------------------------------------
// swr_ctrl
// stack sequencer: push, pop and the in-place swap loop of reverse
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [1:0]                   req_mode,
   input  logic [swr_pkg::WordW-1:0]    req_value,
   output logic                         req_ready,
   input  logic                         out_free,
   output swr_pkg::result_type          result,
   output logic [$clog2(DEPTH)-1:0]     rd_addr0,
   output logic [$clog2(DEPTH)-1:0]     rd_addr1,
   input  logic [swr_pkg::WordW-1:0]    rd_data0,
   input  logic [swr_pkg::WordW-1:0]    rd_data1,
   output logic                         wr_en,
   output logic [$clog2(DEPTH)-1:0]     wr_addr,
   output logic [swr_pkg::WordW-1:0]    wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   swr_pkg::state_type        state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             lo_ff, lo_in;
   logic [AW-1:0]             hi_ff, hi_in;
   logic [swr_pkg::WordW-1:0] tmp_ff, tmp_in;
   logic [swr_pkg::WordW-1:0] pend_data_ff, pend_data_in;
   logic [1:0]                pend_status_ff, pend_status_in;
   logic [CW-1:0]             count_dec;

   assign count_dec = count_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swr_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      tmp_ff         <= tmp_in;
      pend_data_ff   <= pend_data_in;
      pend_status_ff <= pend_status_in;
   end

   always_comb begin
      logic       imm;
      logic [1:0] st;
      imm            = 1'b0;
      st             = swr_pkg::STATUS_OK;
      state_in       = state_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      tmp_in         = tmp_ff;
      pend_data_in   = pend_data_ff;
      pend_status_in = pend_status_ff;
      req_ready      = 1'b0;
      rd_addr0       = lo_ff;
      rd_addr1       = hi_ff;
      wr_en          = 1'b0;
      wr_addr        = lo_ff;
      wr_data        = tmp_ff;
      result.load    = 1'b0;
      result.data    = pend_data_ff;
      result.status  = pend_status_ff;
      case (state_ff)
         swr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_mode)
                  swr_pkg::MODE_PUSH: begin
                     imm = 1'b1;
                     if (count_ff >= CW'(DEPTH)) begin
                        st = swr_pkg::STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  swr_pkg::MODE_POP: begin
                     if (count_ff == '0) begin
                        imm = 1'b1;
                        st  = swr_pkg::STATUS_EMPTY;
                     end else begin
                        rd_addr0 = count_dec[AW-1:0];
                        count_in = count_dec;
                        state_in = swr_pkg::ST_POP_WAIT;
                     end
                  end
                  swr_pkg::MODE_REVERSE: begin
                     if (count_ff == '0) begin
                        imm = 1'b1;
                        st  = swr_pkg::STATUS_EMPTY;
                     end else if (count_ff == CW'(1)) begin
                        imm = 1'b1;
                     end else begin
                        lo_in          = '0;
                        hi_in          = count_dec[AW-1:0];
                        rd_addr0       = '0;
                        rd_addr1       = count_dec[AW-1:0];
                        pend_data_in   = '0;
                        pend_status_in = swr_pkg::STATUS_OK;
                        state_in       = swr_pkg::ST_SWAP_LO;
                     end
                  end
                  default: begin
                     imm = 1'b1;
                  end
               endcase
               if (imm) begin
                  if (out_free) begin
                     result.load   = 1'b1;
                     result.data   = '0;
                     result.status = st;
                  end else begin
                     pend_data_in   = '0;
                     pend_status_in = st;
                     state_in       = swr_pkg::ST_FINISH;
                  end
               end
            end
         end
         swr_pkg::ST_POP_WAIT: begin
            pend_data_in   = rd_data0;
            pend_status_in = swr_pkg::STATUS_OK;
            state_in       = swr_pkg::ST_FINISH;
         end
         swr_pkg::ST_SWAP_LO: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data1;
            tmp_in   = rd_data0;
            state_in = swr_pkg::ST_SWAP_HI;
         end
         swr_pkg::ST_SWAP_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = tmp_ff;
            lo_in    = lo_ff + AW'(1);
            hi_in    = hi_ff - AW'(1);
            rd_addr0 = lo_in;
            rd_addr1 = hi_in;
            if (lo_in < hi_in) begin
               state_in = swr_pkg::ST_SWAP_LO;
            end else begin
               state_in = swr_pkg::ST_FINISH;
            end
         end
         swr_pkg::ST_FINISH: begin
            if (out_free) begin
               result.load = 1'b1;
               state_in    = swr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swr_pkg::ST_IDLE;
         end
      endcase
      result.depth_now = swr_pkg::DepthW'(count_in);
   end

endmodule

>>> hw/rtl/stack_with_reverse.sv
// ----------------------------------------------------------------------------
// stack_with_reverse
// lifo stack of 32-bit words with push, pop and in-place reverse
// ----------------------------------------------------------------------------
// Every request transfer gives exactly one response transfer carrying the
// popped word, a status code and the element count after the operation. A
// push, any operation that fails, a reverse of one element and the unused
// mode are answered from the idle state at once if the response register is
// free; a pop waits in a state for the synchronous read of the element store.
// A reverse of n elements swaps floor(n/2) pairs of words through the single
// write port of the store, in a low and a high swap state per pair. The
// response register lets a new request transfer in while a finished response
// still waits. The store needs no clearing pass, only the count is reset.
`timescale 1ns / 1ps

module stack_with_reverse #(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   swr_req_if.sink   req_chan,
   swr_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0]              rd_addr0;
   logic [AW-1:0]              rd_addr1;
   logic [swr_pkg::WordW-1:0]  rd_data0;
   logic [swr_pkg::WordW-1:0]  rd_data1;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [swr_pkg::WordW-1:0]  wr_data;
   logic                       out_free;
   swr_pkg::result_type        result;

   logic                       rsp_valid_ff;
   logic [swr_pkg::WordW-1:0]  rsp_data_ff;
   logic [1:0]                 rsp_status_ff;
   logic [swr_pkg::DepthW-1:0] rsp_depth_ff;

   swr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_value (req_chan.value),
      .req_ready (req_chan.ready),
      .out_free  (out_free),
      .result    (result),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   swr_mem #(.DEPTH(DEPTH)) u_mem (
      .clock    (clock),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_data_ff   <= result.data;
         rsp_status_ff <= result.status;
         rsp_depth_ff  <= result.depth_now;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.data      = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.depth_now = rsp_depth_ff;

endmodule

>>> hw/rtl/swr_checker.sv
// ----------------------------------------------------------------------------
// swr_checker
// port-level checks of the stack, attached to the top level by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_with_reverse_defines.svh"

module swr_checker #(
   parameter int DEPTH = 64
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [swr_pkg::WordW-1:0]    rsp_data,
   input logic [1:0]                   rsp_status,
   input logic [swr_pkg::DepthW-1:0]   rsp_depth_now
);

   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // requests transferred whose response has not yet transferred
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_xfer && !rsp_xfer) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `SWR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status) && $stable(rsp_depth_now), "stalled response changed")
   `SWR_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> outstanding_ff != 2'd0 && outstanding_ff != 2'd3, "response without matching request")
   `SWR_ASSERT(a_overflow_full, clock, reset, rsp_valid && rsp_status == swr_pkg::STATUS_OVERFLOW |-> rsp_depth_now == swr_pkg::DepthW'(DEPTH) && rsp_data == '0, "overflow reported below full")
   `SWR_ASSERT(a_empty_zero, clock, reset, rsp_valid && rsp_status == swr_pkg::STATUS_EMPTY |-> rsp_depth_now == '0 && rsp_data == '0, "empty reported with elements stored")

endmodule

bind stack_with_reverse swr_checker #(.DEPTH(DEPTH)) u_swr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_data      (rsp_chan.data),
   .rsp_status    (rsp_chan.status),
   .rsp_depth_now (rsp_chan.depth_now)
);

>>> test/stack_with_reverse_check.sv
// ----------------------------------------------------------------------------
// stack_with_reverse_check
// response prediction and comparison for the reversible lifo stack
// ----------------------------------------------------------------------------
// Watches both channels. Every request transfer is applied to a private copy
// of the stack and the resulting response is queued. Every response transfer
// is compared with the oldest queued response. The mismatch count and the
// number of responses still due are handed to the testbench top.
`timescale 1ns / 1ps

module stack_with_reverse_check #(
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   swr_req_if   req_chan,
   swr_rsp_if   rsp_chan,
   output int   mismatch_count,
   output int   results_due
);

   typedef struct {
      logic [swr_pkg::WordW-1:0]  data;
      logic [1:0]                 status;
      logic [swr_pkg::DepthW-1:0] depth_now;
   } stack_result_type;

   logic [swr_pkg::WordW-1:0] shadow_words [DEPTH];
   int unsigned               shadow_level;
   stack_result_type          due_responses [$];

   initial begin
      mismatch_count = 0;
      results_due    = 0;
      shadow_level   = 0;
   end

   function automatic stack_result_type apply_op(input logic [1:0] mode,
                                                 input logic [swr_pkg::WordW-1:0] value);
      stack_result_type          r;
      logic [swr_pkg::WordW-1:0] t;
      int unsigned               lo;
      int unsigned               hi;
      r.data   = '0;
      r.status = swr_pkg::STATUS_OK;
      case (mode)
         swr_pkg::MODE_PUSH: begin
            if (shadow_level >= DEPTH) begin
               r.status = swr_pkg::STATUS_OVERFLOW;
            end else begin
               shadow_words[shadow_level] = value;
               shadow_level++;
            end
         end
         swr_pkg::MODE_POP: begin
            if (shadow_level == 0) begin
               r.status = swr_pkg::STATUS_EMPTY;
            end else begin
               shadow_level--;
               r.data = shadow_words[shadow_level];
            end
         end
         swr_pkg::MODE_REVERSE: begin
            if (shadow_level == 0) begin
               r.status = swr_pkg::STATUS_EMPTY;
            end else begin
               lo = 0;
               hi = shadow_level - 1;
               while (lo < hi) begin
                  t                = shadow_words[lo];
                  shadow_words[lo] = shadow_words[hi];
                  shadow_words[hi] = t;
                  lo++;
                  hi--;
               end
            end
         end
         default: ;
      endcase
      r.depth_now = shadow_level[swr_pkg::DepthW-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         shadow_level = 0;
         due_responses.delete();
         results_due = 0;
      end else begin
         // response first: a response never belongs to a request of this edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response transfer: data %h status %0d depth %0d",
                           rsp_chan.data, rsp_chan.status, rsp_chan.depth_now);
            end else begin
               want = due_responses.pop_front();
               if (rsp_chan.data !== want.data || rsp_chan.status !== want.status ||
                   rsp_chan.depth_now !== want.depth_now) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"response mismatch: expected data %h status %0d depth %0d,",
                               " got data %h status %0d depth %0d"},
                              want.data, want.status, want.depth_now,
                              rsp_chan.data, rsp_chan.status, rsp_chan.depth_now);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            due_responses.push_back(apply_op(req_chan.mode, req_chan.value));
         results_due = due_responses.size();
      end
   end

endmodule

>>> test/stack_with_reverse_tb.sv
// ----------------------------------------------------------------------------
// stack_with_reverse_tb
// stimulus and verdict for the reversible lifo stack
// ----------------------------------------------------------------------------
// A directed opening covers empty pops and reverses, the unused mode, a
// reverse of one element and extreme words. The random part mixes single
// operations with runs that fill the stack to overflow and drain it past
// empty. Both sides idle at random, the response side once holds off for a
// long stretch while requests keep coming, and the request side once waits
// until every response is back. A separate module predicts and compares.
`timescale 1ns / 1ps

module stack_with_reverse_tb;

   localparam int StackDepth  = 64;
   localparam int TotalItems  = 420;
   localparam int IdleLimit   = 5000;
   localparam int LongHold    = 300;
   localparam int DrainCycles = 200;

   logic clock = 1'b0;
   logic reset;

   swr_req_if req_chan ();
   swr_rsp_if rsp_chan ();

   int mismatch_count;
   int results_due;
   int fill_level   = 0;
   int total_sent   = 0;
   int idle_cycles  = 0;
   int holds_asked  = 0;
   int holds_served = 0;
   bit fast_run     = 1'b0;
   bit pressed      = 1'b0;
   bit paused       = 1'b0;

   stack_with_reverse #(.DEPTH(StackDepth)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stack_with_reverse_check #(.DEPTH(StackDepth)) check_i (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap();
      if ($urandom_range(0, 15) == 0)
         fast_run = !fast_run;
      if (fast_run)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic logic [swr_pkg::WordW-1:0] draw_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(input logic [1:0] mode, input logic [swr_pkg::WordW-1:0] value,
                          input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode  <= mode;
      req_chan.value <= value;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      if (mode == swr_pkg::MODE_PUSH && fill_level < StackDepth)
         fill_level++;
      else if (mode == swr_pkg::MODE_POP && fill_level > 0)
         fill_level--;
      total_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_op(input int gap);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 8)
         send_op(swr_pkg::MODE_PUSH, draw_word(), gap);
      else if (pick < 15)
         send_op(swr_pkg::MODE_POP, draw_word(), gap);
      else if (pick < 18)
         send_op(swr_pkg::MODE_REVERSE, draw_word(), gap);
      else
         send_op(swr_pkg::MODE_UNUSED, draw_word(), gap);
   endtask

   // response side
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (holds_asked > holds_served) begin
            holds_served++;
            gap = LongHold;
         end else if (fast_run) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // request side
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode  = swr_pkg::MODE_PUSH;
      req_chan.value = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening
      send_op(swr_pkg::MODE_POP, 32'h1234_5678, draw_gap());
      send_op(swr_pkg::MODE_REVERSE, 32'hFFFF_FFFF, draw_gap());
      send_op(swr_pkg::MODE_UNUSED, 32'hFFFF_FFFF, draw_gap());
      send_op(swr_pkg::MODE_PUSH, 32'hFFFF_FFFF, draw_gap());
      send_op(swr_pkg::MODE_REVERSE, '0, draw_gap());
      send_op(swr_pkg::MODE_POP, '0, draw_gap());
      send_op(swr_pkg::MODE_PUSH, 32'h0000_0000, draw_gap());
      send_op(swr_pkg::MODE_PUSH, 32'hAAAA_AAAA, draw_gap());
      send_op(swr_pkg::MODE_PUSH, 32'h5555_5555, draw_gap());
      send_op(swr_pkg::MODE_REVERSE, '0, draw_gap());
      send_op(swr_pkg::MODE_UNUSED, 32'hDEAD_BEEF, draw_gap());
      send_op(swr_pkg::MODE_POP, '0, draw_gap());
      send_op(swr_pkg::MODE_REVERSE, '0, draw_gap());
      send_op(swr_pkg::MODE_PUSH, 32'h8000_0001, 0);
      send_op(swr_pkg::MODE_REVERSE, '0, 0);
      send_op(swr_pkg::MODE_POP, '0, 0);
      send_op(swr_pkg::MODE_POP, '0, draw_gap());
      send_op(swr_pkg::MODE_POP, '0, draw_gap());
      send_op(swr_pkg::MODE_POP, '0, draw_gap());

      while (total_sent < TotalItems) begin
         if (!pressed && total_sent >= 150) begin
            pressed = 1'b1;
            holds_asked++;
            repeat (30) send_random_op(0);
         end
         if (!paused && total_sent >= 300) begin
            paused = 1'b1;
            req_chan.valid <= 1'b0;
            wait (results_due == 0);
            @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0: begin
               // fill to full, overflow, then reverse the full stack
               while (fill_level < StackDepth)
                  send_op(swr_pkg::MODE_PUSH, draw_word(), draw_gap());
               repeat ($urandom_range(1, 3))
                  send_op(swr_pkg::MODE_PUSH, draw_word(), draw_gap());
               send_op(swr_pkg::MODE_REVERSE, draw_word(), draw_gap());
            end
            1: begin
               // drain past empty with occasional reverses
               while (fill_level > 0) begin
                  if ($urandom_range(0, 7) == 0)
                     send_op(swr_pkg::MODE_REVERSE, draw_word(), draw_gap());
                  else
                     send_op(swr_pkg::MODE_POP, draw_word(), draw_gap());
               end
               repeat ($urandom_range(1, 2))
                  send_op(swr_pkg::MODE_POP, draw_word(), draw_gap());
               if ($urandom_range(0, 1) == 0)
                  send_op(swr_pkg::MODE_REVERSE, draw_word(), draw_gap());
            end
            default: send_random_op(draw_gap());
         endcase
      end

      req_chan.valid <= 1'b0;
      wait (results_due == 0);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
